### sv/vgph_pkg.sv
// shared types and constants for the voxel grid point histogram
// no dependencies

package vgph_pkg;

  localparam int COORD_W   = 32;
  localparam int RECIP_W   = 32;
  localparam int PROD_W    = COORD_W + RECIP_W;
  localparam int INDEX_W   = 15;
  localparam int OUTCNT_W  = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;

  localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Z_ORIGIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_X_RECIP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Y_RECIP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Z_RECIP  = 3'd5;

  localparam logic KIND_ACCUM = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_MAP,
    ST_RD,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic  clr_en;
    logic  load;
    logic  mul_en;
    logic  map_en;
    logic  rd_en;
    logic  upd_en;
    axis_t axis;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
  } status_t;

endpackage

### sv/vgph_ctrl.sv
// controller state machine: clearing pass, axis sequencing, memory update
// depends on vgph_pkg

module vgph_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               kind,
  input  vgph_pkg::status_t  status,
  output vgph_pkg::cmd_t     cmd,
  output logic               busy
);

  vgph_pkg::state_t state, state_next;
  vgph_pkg::axis_t  axis, axis_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vgph_pkg::ST_CLEAR;
      axis  <= vgph_pkg::AXIS_X;
    end else begin
      state <= state_next;
      axis  <= axis_next;
    end
  end

  always_comb begin
    state_next = state;
    axis_next  = axis;
    case (state)
      vgph_pkg::ST_CLEAR: begin
        if (status.clr_last) state_next = vgph_pkg::ST_IDLE;
      end
      vgph_pkg::ST_IDLE: begin
        axis_next = vgph_pkg::AXIS_X;
        if (start) begin
          state_next = (kind == vgph_pkg::KIND_READ) ? vgph_pkg::ST_RD : vgph_pkg::ST_MUL;
        end
      end
      vgph_pkg::ST_MUL: begin
        state_next = vgph_pkg::ST_MAP;
      end
      vgph_pkg::ST_MAP: begin
        case (axis)
          vgph_pkg::AXIS_X: begin
            axis_next  = vgph_pkg::AXIS_Y;
            state_next = vgph_pkg::ST_MUL;
          end
          vgph_pkg::AXIS_Y: begin
            axis_next  = vgph_pkg::AXIS_Z;
            state_next = vgph_pkg::ST_MUL;
          end
          default: begin
            axis_next  = vgph_pkg::AXIS_X;
            state_next = vgph_pkg::ST_RD;
          end
        endcase
      end
      vgph_pkg::ST_RD: begin
        state_next = vgph_pkg::ST_UPD;
      end
      vgph_pkg::ST_UPD: begin
        state_next = vgph_pkg::ST_IDLE;
      end
      default: begin
        state_next = vgph_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.axis   = axis;
    busy       = 1'b1;
    case (state)
      vgph_pkg::ST_CLEAR: cmd.clr_en = 1'b1;
      vgph_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      vgph_pkg::ST_MUL:   cmd.mul_en = 1'b1;
      vgph_pkg::ST_MAP:   cmd.map_en = 1'b1;
      vgph_pkg::ST_RD:    cmd.rd_en  = 1'b1;
      vgph_pkg::ST_UPD:   cmd.upd_en = 1'b1;
      default:            busy = 1'b1;
    endcase
  end

endmodule

### sv/vgph_datapath.sv
// datapath: config registers, shared axis multiplier, cell count memory, result registers
// depends on vgph_pkg

module vgph_datapath #(
  parameter int GRID_BITS  = 5,
  parameter int COUNT_BITS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  vgph_pkg::cmd_t                         cmd,
  output vgph_pkg::status_t                      status,
  input  logic                                   cfg_we,
  input  logic [vgph_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [vgph_pkg::CFG_W-1:0]             cfg_data,
  input  logic                                   kind,
  input  logic signed [vgph_pkg::COORD_W-1:0]    coord_x,
  input  logic signed [vgph_pkg::COORD_W-1:0]    coord_y,
  input  logic signed [vgph_pkg::COORD_W-1:0]    coord_z,
  input  logic [vgph_pkg::INDEX_W-1:0]           read_index,
  output logic                                   done,
  output logic [vgph_pkg::INDEX_W-1:0]           cell_index,
  output logic                                   clamped,
  output logic [vgph_pkg::OUTCNT_W-1:0]          cell_count
);

  localparam int CELL_BITS  = 3 * GRID_BITS;
  localparam int CELL_TOTAL = 2 ** CELL_BITS;
  localparam logic [vgph_pkg::RECIP_W-1:0] GRID_SIDE =
    vgph_pkg::RECIP_W'(1) << GRID_BITS;

  logic signed [vgph_pkg::COORD_W-1:0] origin [3];
  logic [vgph_pkg::RECIP_W-1:0]        recip  [3];
  logic signed [vgph_pkg::COORD_W:0]   offset [3];
  logic [GRID_BITS-1:0]                cell_coord [3];
  logic                                kind_q;
  logic [vgph_pkg::INDEX_W-1:0]        read_index_q;
  logic                                flag;
  logic [vgph_pkg::PROD_W-1:0]         product;
  logic [CELL_BITS-1:0]                clr_addr;
  logic [CELL_BITS-1:0]                addr_q;
  logic [COUNT_BITS-1:0]               rdata;
  logic [COUNT_BITS-1:0]               mem [CELL_TOTAL];

  logic [vgph_pkg::COORD_W-1:0]          dist_lo;
  logic                                  dist_neg;
  logic [vgph_pkg::RECIP_W-1:0]          prod_hi;
  logic [vgph_pkg::RECIP_W-1:0]          prod_lo;
  logic                                  over;
  logic                                  exact_max;
  logic [GRID_BITS-1:0]                  cell_sel;
  logic [CELL_BITS+vgph_pkg::INDEX_W-1:0] rix_ext;
  logic [CELL_BITS-1:0]                  rd_addr;
  logic [COUNT_BITS-1:0]                 count_inc;
  logic [COUNT_BITS-1:0]                 count_val;
  logic [COUNT_BITS+vgph_pkg::OUTCNT_W-1:0] count_ext;
  logic [CELL_BITS+vgph_pkg::INDEX_W-1:0] idx_ext;
  logic                                  mem_we;
  logic [CELL_BITS-1:0]                  mem_waddr;
  logic [COUNT_BITS-1:0]                 mem_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin[0] <= '0;
      origin[1] <= '0;
      origin[2] <= '0;
      recip[0]  <= '0;
      recip[1]  <= '0;
      recip[2]  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        vgph_pkg::REG_X_ORIGIN: origin[0] <= cfg_data;
        vgph_pkg::REG_Y_ORIGIN: origin[1] <= cfg_data;
        vgph_pkg::REG_Z_ORIGIN: origin[2] <= cfg_data;
        vgph_pkg::REG_X_RECIP:  recip[0]  <= cfg_data;
        vgph_pkg::REG_Y_RECIP:  recip[1]  <= cfg_data;
        vgph_pkg::REG_Z_RECIP:  recip[2]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // offsets from the grid origin, exact in 33 bits
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      offset[0]    <= {coord_x[vgph_pkg::COORD_W-1], coord_x}
                      - {origin[0][vgph_pkg::COORD_W-1], origin[0]};
      offset[1]    <= {coord_y[vgph_pkg::COORD_W-1], coord_y}
                      - {origin[1][vgph_pkg::COORD_W-1], origin[1]};
      offset[2]    <= {coord_z[vgph_pkg::COORD_W-1], coord_z}
                      - {origin[2][vgph_pkg::COORD_W-1], origin[2]};
      kind_q       <= kind;
      read_index_q <= read_index;
    end
  end

  assign dist_lo  = offset[cmd.axis][vgph_pkg::COORD_W-1:0];
  assign dist_neg = offset[cmd.axis][vgph_pkg::COORD_W];

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      product <= vgph_pkg::PROD_W'(dist_lo) * vgph_pkg::PROD_W'(recip[cmd.axis]);
    end
  end

  assign prod_hi   = product[vgph_pkg::PROD_W-1:vgph_pkg::RECIP_W];
  assign prod_lo   = product[vgph_pkg::RECIP_W-1:0];
  assign over      = prod_hi >= GRID_SIDE;
  assign exact_max = (prod_hi == GRID_SIDE) && (prod_lo == '0);

  always_comb begin
    if (dist_neg) begin
      cell_sel = '0;
    end else if (over) begin
      cell_sel = '1;
    end else begin
      cell_sel = prod_hi[GRID_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      flag <= 1'b0;
    end else if (cmd.map_en) begin
      cell_coord[cmd.axis] <= cell_sel;
      flag                 <= flag | dist_neg | (over & ~exact_max);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_en) begin
      clr_addr <= clr_addr + CELL_BITS'(1);
    end
  end

  assign status.clr_last = &clr_addr;

  assign rix_ext = {{CELL_BITS{1'b0}}, read_index_q};
  assign rd_addr = (kind_q == vgph_pkg::KIND_READ) ? rix_ext[CELL_BITS-1:0]
                                                    : {cell_coord[0], cell_coord[1],
                                                       cell_coord[2]};

  assign count_inc = (&rdata) ? rdata : rdata + COUNT_BITS'(1);
  assign count_val = (kind_q == vgph_pkg::KIND_READ) ? rdata : count_inc;

  assign mem_we    = cmd.clr_en | (cmd.upd_en & (kind_q == vgph_pkg::KIND_ACCUM));
  assign mem_waddr = cmd.clr_en ? clr_addr : addr_q;
  assign mem_wdata = cmd.clr_en ? '0 : count_inc;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata  <= mem[rd_addr];
      addr_q <= rd_addr;
    end
  end

  assign count_ext = {{vgph_pkg::OUTCNT_W{1'b0}}, count_val};
  assign idx_ext   = {{vgph_pkg::INDEX_W{1'b0}}, addr_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.upd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd_en) begin
      cell_index <= idx_ext[vgph_pkg::INDEX_W-1:0];
      clamped    <= (kind_q == vgph_pkg::KIND_ACCUM) & flag;
      cell_count <= count_ext[vgph_pkg::OUTCNT_W-1:0];
    end
  end

endmodule

### sv/voxel_grid_point_histogram.sv
// top level of the voxel grid point histogram: controller plus datapath
// depends on vgph_pkg, vgph_ctrl, vgph_datapath

// After reset the block clears all 2^(3*GRID_BITS) cells of its count store
// (32768 at the default), one cell per cycle; busy is high during the pass
// and configuration writes are still taken. An accumulate item passes through
// a multiply and a map state for each axis in turn, because one 32x32 multiplier
// serves the three axes, followed by a read and a write of the single-port count
// memory; a read item passes through the read and update states only. The result
// appears in the first cycle with busy low, with done high for that one cycle;
// the receiver cannot stall, so it must take the result then. A new item may be
// started in that same cycle.

module voxel_grid_point_histogram #(
  parameter int GRID_BITS  = 5,
  parameter int COUNT_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 kind,
  input  logic signed [vgph_pkg::COORD_W-1:0]  coord_x,
  input  logic signed [vgph_pkg::COORD_W-1:0]  coord_y,
  input  logic signed [vgph_pkg::COORD_W-1:0]  coord_z,
  input  logic [vgph_pkg::INDEX_W-1:0]         read_index,
  output logic                                 done,
  output logic [vgph_pkg::INDEX_W-1:0]         cell_index,
  output logic                                 clamped,
  output logic [vgph_pkg::OUTCNT_W-1:0]        cell_count,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [vgph_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vgph_pkg::CFG_W-1:0]           cfg_data
);

  vgph_pkg::cmd_t    cmd;
  vgph_pkg::status_t status;

  assign cfg_ready = 1'b1;

  vgph_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .kind   (kind),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  vgph_datapath #(
    .GRID_BITS  (GRID_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_we     (cfg_valid & cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .kind       (kind),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .coord_z    (coord_z),
    .read_index (read_index),
    .done       (done),
    .cell_index (cell_index),
    .clamped    (clamped),
    .cell_count (cell_count)
  );

endmodule

### sv/vgph_checker.sv
// port-level checks for the voxel grid point histogram, bound to the top level
// depends on voxel_grid_point_histogram

module vgph_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // an accepted transaction holds the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // results are single-cycle strobes
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  // a result only shows once the work is finished
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  // a result follows work, never an idle cycle
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without preceding work");

endmodule

bind voxel_grid_point_histogram vgph_checker u_vgph_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

### verif/testbench.sv
// self-checking testbench for voxel_grid_point_histogram
// depends on vgph_pkg and the block's RTL; predicts every result in a scoreboard class

module testbench;

  localparam int GRID_BITS  = 5;
  localparam int COUNT_BITS = 32;
  localparam int SIDE       = 1 << GRID_BITS;
  localparam int CELLS      = 1 << (3 * GRID_BITS);
  localparam int QUIET_LIMIT = 150000;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_ITEMS = 70;
  localparam logic [vgph_pkg::CFG_IDX_W-1:0] ORIGIN_REG [3] =
    '{vgph_pkg::REG_X_ORIGIN, vgph_pkg::REG_Y_ORIGIN, vgph_pkg::REG_Z_ORIGIN};
  localparam logic [vgph_pkg::CFG_IDX_W-1:0] RECIP_REG [3]  =
    '{vgph_pkg::REG_X_RECIP, vgph_pkg::REG_Y_RECIP, vgph_pkg::REG_Z_RECIP};

  typedef struct {
    bit [vgph_pkg::INDEX_W-1:0]  index;
    bit                          clamped;
    bit [vgph_pkg::OUTCNT_W-1:0] count;
  } cell_result_t;

  class voxel_count_board;
    cell_result_t                        expected_cells[$];
    bit [vgph_pkg::OUTCNT_W-1:0]         cell_store [0:CELLS-1];
    logic signed [vgph_pkg::COORD_W-1:0] origin [3];
    bit [vgph_pkg::RECIP_W-1:0]          recip [3];
    int                                  mismatches;

    function new();
      for (int a = 0; a < 3; a++) begin
        origin[a] = '0;
        recip[a] = '0;
      end
      mismatches = 0;
    endfunction

    function void apply_reg(logic [vgph_pkg::CFG_IDX_W-1:0] index,
                            logic [vgph_pkg::CFG_W-1:0] data);
      case (index)
        vgph_pkg::REG_X_ORIGIN: origin[0] = data;
        vgph_pkg::REG_Y_ORIGIN: origin[1] = data;
        vgph_pkg::REG_Z_ORIGIN: origin[2] = data;
        vgph_pkg::REG_X_RECIP:  recip[0] = data;
        vgph_pkg::REG_Y_RECIP:  recip[1] = data;
        vgph_pkg::REG_Z_RECIP:  recip[2] = data;
        default: ;
      endcase
    endfunction

    // returns {clamp flag, cell coordinate}
    function bit [GRID_BITS:0] axis_cell(logic signed [vgph_pkg::COORD_W-1:0] coord,
                                         logic signed [vgph_pkg::COORD_W-1:0] org,
                                         bit [vgph_pkg::RECIP_W-1:0] rcp);
      longint delta;
      bit [vgph_pkg::PROD_W-1:0] delta_u;
      bit [vgph_pkg::PROD_W-1:0] prod;
      delta = longint'(coord) - longint'(org);
      if (delta < 0) return {1'b1, {GRID_BITS{1'b0}}};
      delta_u = delta;
      prod = delta_u * {32'b0, rcp};
      if (prod[vgph_pkg::PROD_W-1:32] >= SIDE) begin
        if (prod != (64'(SIDE) << 32)) return {1'b1, {GRID_BITS{1'b1}}};
        return {1'b0, {GRID_BITS{1'b1}}};
      end
      return {1'b0, prod[32 +: GRID_BITS]};
    endfunction

    function void note_item(logic k, logic signed [vgph_pkg::COORD_W-1:0] x,
                            logic signed [vgph_pkg::COORD_W-1:0] y,
                            logic signed [vgph_pkg::COORD_W-1:0] z,
                            logic [vgph_pkg::INDEX_W-1:0] ri);
      cell_result_t res;
      bit [GRID_BITS:0] cx, cy, cz;
      if (k == vgph_pkg::KIND_READ) begin
        res.index = ri;
        res.clamped = 1'b0;
        res.count = cell_store[res.index];
      end else begin
        cx = axis_cell(x, origin[0], recip[0]);
        cy = axis_cell(y, origin[1], recip[1]);
        cz = axis_cell(z, origin[2], recip[2]);
        res.index = {cx[GRID_BITS-1:0], cy[GRID_BITS-1:0], cz[GRID_BITS-1:0]};
        res.clamped = cx[GRID_BITS] | cy[GRID_BITS] | cz[GRID_BITS];
        if (cell_store[res.index] != '1) cell_store[res.index]++;
        res.count = cell_store[res.index];
      end
      expected_cells.push_back(res);
    endfunction

    function void check_result(logic [vgph_pkg::INDEX_W-1:0] idx, logic clp,
                               logic [vgph_pkg::OUTCNT_W-1:0] cnt);
      cell_result_t want;
      if (expected_cells.size() == 0) begin
        mismatches++;
        $display("%0t: result with no item pending: expected none, got index %0h count %0h",
                 $time, idx, cnt);
        return;
      end
      want = expected_cells.pop_front();
      if (idx !== want.index) begin
        mismatches++;
        $display("%0t: cell_index expected %0h, got %0h", $time, want.index, idx);
      end
      if (clp !== want.clamped) begin
        mismatches++;
        $display("%0t: clamped expected %0b, got %0b", $time, want.clamped, clp);
      end
      if (cnt !== want.count) begin
        mismatches++;
        $display("%0t: cell_count expected %0h, got %0h", $time, want.count, cnt);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic kind;
  logic signed [vgph_pkg::COORD_W-1:0] coord_x, coord_y, coord_z;
  logic [vgph_pkg::INDEX_W-1:0]  read_index;
  logic done;
  logic [vgph_pkg::INDEX_W-1:0]  cell_index;
  logic clamped;
  logic [vgph_pkg::OUTCNT_W-1:0] cell_count;
  logic cfg_valid;
  logic cfg_ready;
  logic [vgph_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [vgph_pkg::CFG_W-1:0]     cfg_data;

  voxel_count_board board;
  logic signed [vgph_pkg::COORD_W-1:0] cur_origin [3];
  bit [vgph_pkg::RECIP_W-1:0] cur_recip [3];
  longint cur_width [3];
  int idle_pct;
  int quiet_cycles;
  int items_taken, reads_taken, results_seen, clamp_seen, settings;
  logic [vgph_pkg::INDEX_W-1:0] last_cell;

  voxel_grid_point_histogram #(
    .GRID_BITS (GRID_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .kind      (kind),
    .coord_x   (coord_x),
    .coord_y   (coord_y),
    .coord_z   (coord_z),
    .read_index(read_index),
    .done      (done),
    .cell_index(cell_index),
    .clamped   (clamped),
    .cell_count(cell_count),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && board != null) begin
      if (cfg_valid && cfg_ready) board.apply_reg(cfg_index, cfg_data);
      if (done) begin
        board.check_result(cell_index, clamped, cell_count);
        results_seen++;
        last_cell = cell_index;
        if (clamped) clamp_seen++;
      end
      if (start && !busy) begin
        board.note_item(kind, coord_x, coord_y, coord_z, read_index);
        items_taken++;
        if (kind == vgph_pkg::KIND_READ) reads_taken++;
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic longint width_of(bit [vgph_pkg::RECIP_W-1:0] rcp);
    longint w;
    if (rcp == 0) return 1;
    w = ((64'd1 << 32) + rcp - 1) / rcp;
    if (w > (64'd1 << 26)) w = 64'd1 << 26;
    return w;
  endfunction

  task automatic write_config();
    for (int a = 0; a < 3; a++) begin
      cfg_valid = 1'b1;
      cfg_index = ORIGIN_REG[a];
      cfg_data = cur_origin[a];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
      cfg_index = RECIP_REG[a];
      cfg_data = cur_recip[a];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
      cur_width[a] = width_of(cur_recip[a]);
    end
    cfg_valid = 1'b0;
    settings++;
  endtask

  task automatic set_grid(logic signed [vgph_pkg::COORD_W-1:0] org,
                          bit [vgph_pkg::RECIP_W-1:0] rcp);
    for (int a = 0; a < 3; a++) begin
      cur_origin[a] = org;
      cur_recip[a] = rcp;
    end
    write_config();
  endtask

  task automatic send_item(logic k, logic signed [vgph_pkg::COORD_W-1:0] x,
                           logic signed [vgph_pkg::COORD_W-1:0] y,
                           logic signed [vgph_pkg::COORD_W-1:0] z,
                           logic [vgph_pkg::INDEX_W-1:0] ri);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    kind = k;
    coord_x = x;
    coord_y = y;
    coord_z = z;
    read_index = ri;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic point(logic signed [vgph_pkg::COORD_W-1:0] x,
                       logic signed [vgph_pkg::COORD_W-1:0] y,
                       logic signed [vgph_pkg::COORD_W-1:0] z);
    send_item(vgph_pkg::KIND_ACCUM, x, y, z, vgph_pkg::INDEX_W'($urandom));
  endtask

  task automatic read_cell(logic [vgph_pkg::INDEX_W-1:0] ri);
    send_item(vgph_pkg::KIND_READ, $urandom, $urandom, $urandom, ri);
  endtask

  task automatic drain_results();
    start = 1'b0;
    while (board.expected_cells.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  function automatic logic signed [vgph_pkg::COORD_W-1:0] near_grid(int a);
    longint w;
    longint off;
    int sel;
    w = cur_width[a];
    sel = $urandom_range(9);
    if (sel == 0) off = -longint'($urandom_range(32'(4 * w), 1));
    else if (sel == 1) off = 32 * w + $urandom_range(32'(4 * w), 0);
    else if (sel < 5) off = $urandom_range(32'(2 * w - 1), 0);
    else off = $urandom_range(32'(32 * w - 1), 0);
    return vgph_pkg::COORD_W'(longint'(cur_origin[a]) + off);
  endfunction

  task automatic random_item();
    int r;
    logic [vgph_pkg::INDEX_W-1:0] ri;
    r = $urandom_range(99);
    if (r < 8) begin
      send_item(1'($urandom_range(1)), $urandom, $urandom, $urandom,
                vgph_pkg::INDEX_W'($urandom));
    end else if (r < 28) begin
      ri = ($urandom_range(1) == 1) ? last_cell : vgph_pkg::INDEX_W'($urandom);
      read_cell(ri);
    end else begin
      point(near_grid(0), near_grid(1), near_grid(2));
    end
  endtask

  task automatic random_config(bit full);
    int e;
    longint w;
    for (int a = 0; a < 3; a++) begin
      if (full) begin
        cur_origin[a] = $urandom;
        cur_recip[a] = $urandom;
      end else begin
        e = $urandom_range(18);
        w = (64'd1 << e) + (($urandom_range(1) == 1) ? 0 : $urandom_range((1 << e) - 1, 0));
        cur_recip[a] = (w == 1) ? 32'hFFFF_FFFF : vgph_pkg::RECIP_W'((64'd1 << 32) / w);
        if ($urandom_range(7) == 0) cur_recip[a] = '0;
        cur_origin[a] = $signed($urandom) >>> 2;
      end
    end
    write_config();
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    start = 1'b0;
    kind = vgph_pkg::KIND_ACCUM;
    coord_x = '0;
    coord_y = '0;
    coord_z = '0;
    read_index = '0;
    cfg_valid = 1'b0;
    cfg_index = vgph_pkg::REG_X_ORIGIN;
    cfg_data = '0;
    idle_pct = 0;
    quiet_cycles = 0;
    items_taken = 0;
    reads_taken = 0;
    results_seen = 0;
    clamp_seen = 0;
    settings = 1;
    last_cell = '0;
    for (int a = 0; a < 3; a++) begin
      cur_origin[a] = '0;
      cur_recip[a] = '0;
      cur_width[a] = 1;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: zero reciprocal puts every point in cell 0
    point(32'sd0, 32'sd0, 32'sd0);
    point(-32'sd1, 32'sd5, 32'sd7);
    point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    read_cell('0);
    read_cell('1);
    drain_results();

    // cells 32 units wide from zero
    set_grid(32'sd0, 32'h0800_0000);
    point(32'sd1024, 32'sd1024, 32'sd1024);
    point(32'sd1025, 32'sd0, 32'sd0);
    point(32'sd0, 32'sd1023, 32'sd1023);
    point(-32'sd1, 32'sd40, -32'sd700);
    point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    point(32'sd31, 32'sd32, 32'sd63);
    read_cell('1);
    read_cell(15'd1023);
    drain_results();

    // origin at the most negative value, largest reciprocal
    set_grid(32'h8000_0000, 32'hFFFF_FFFF);
    point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    point(32'h8000_0001, 32'h8000_0002, 32'h8000_0021);
    point(32'h8000_0020, 32'h8000_0020, 32'h8000_0020);
    point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    drain_results();

    // origin at the most positive value
    set_grid(32'h7FFF_FFFF, 32'h8000_0000);
    point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    point(32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    read_cell('0);
    drain_results();

    for (int p = 0; p < RAND_PHASES; p++) begin
      random_config(p % 5 == 4);
      case (p % 3)
        0: idle_pct = 0;
        1: idle_pct = 63;
        default: idle_pct = 9;
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) random_item();
      drain_results();
      idle_pct = 0;
    end

    repeat (12) @(negedge clk);
    if (board.expected_cells.size() != 0) begin
      board.mismatches++;
      $display("%0t: results outstanding: expected 0, got %0d", $time,
               board.expected_cells.size());
    end
    $display("covered %0d items (%0d reads) under %0d register settings", items_taken,
             reads_taken, settings);
    $display("checked %0d results, %0d of them clamped", results_seen, clamp_seen);
    if (board.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
sv/vgph_pkg.sv
sv/vgph_ctrl.sv
sv/vgph_datapath.sv
sv/voxel_grid_point_histogram.sv
sv/vgph_checker.sv
verif/testbench.sv
